// File: hdl/sapq_pkg.sv
package sapq_pkg;

    localparam int VALUE_BITS = 27;
    localparam int unsigned VALUE_LIMIT = 32'd100000000;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic                  op;
        logic [VALUE_BITS-1:0] value;
        logic [5:0]            remove_count;
    } req_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] removed_value;
        logic                  has_value;
        logic                  last;
        logic                  dropped;
        logic [6:0]            occupancy;
    } res_t;

    // what the whole chain does in the current cycle
    typedef struct packed {
        logic insert;
        logic shift;
    } cell_cmd_t;

endpackage

// File: hdl/sapq_cell.sv
module sapq_cell
    import sapq_pkg::*;
(
    input  logic                  clk,
    input  cell_cmd_t             cmd,
    input  logic                  occupied,
    input  logic [VALUE_BITS-1:0] ins_value,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic                  left_gt,
    input  logic [VALUE_BITS-1:0] right_value,
    output logic [VALUE_BITS-1:0] value,
    output logic                  gt
);

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;

    // an empty cell counts as greater so a new value lands at the tail
    assign gt = !occupied || (value_reg > ins_value);
    assign value = value_reg;

    always_comb
    begin
        value_next = value_reg;
        if (cmd.insert && gt)
        begin
            value_next = left_gt ? left_value : ins_value;
        end
        else if (cmd.shift)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: hdl/sorted_array_priority_queue_top.sv
// sorted min-priority queue built as a row of compare-and-shift cells
//
// request channel: an item is transferred at a rising edge with start high
// and busy low. op selects insert or remove.
// result channel: each result is shown on result for one cycle with done
// high; the receiver cannot stall, so no result waits for it.
//
// insert: the value (saturated below the value limit) goes into its sorted
// place, after equal values; the acknowledgement appears the cycle after
// the transfer and busy stays low, so one insert per cycle when not busy.
// a full store drops the value and flags dropped.
// remove: the count is capped at REMOVE_MAX and at the occupancy; n values
// leave the head of the chain, one per cycle, the first one the cycle after
// the transfer. busy is high while the remaining values shift out.
// a capped count of zero gives one empty result the cycle after the transfer.
// reset clears the occupancy and the sequencer; cell contents are only
// read below the occupancy and need no reset.
module sorted_array_priority_queue_top
    import sapq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int REMOVE_MAX = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output res_t result
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int RW = $clog2(REMOVE_MAX + 1);

    logic [FW-1:0] fill_reg;
    logic [FW-1:0] fill_next;
    logic [RW-1:0] rem_reg;
    logic [RW-1:0] rem_next;
    logic          done_reg;
    logic          done_next;
    res_t          res_reg;
    res_t          res_next;

    cell_cmd_t             cmd;
    logic [VALUE_BITS-1:0] ins_value;
    logic [VALUE_BITS-1:0] cell_value [DEPTH];
    logic                  cell_gt    [DEPTH];
    logic [RW-1:0]         cap_count;
    logic [RW-1:0]         take_count;

    assign busy   = (rem_reg != '0);
    assign done   = done_reg;
    assign result = res_reg;

    assign ins_value = (32'(request.value) >= VALUE_LIMIT)
                     ? VALUE_BITS'(VALUE_LIMIT - 1) : request.value;

    assign cap_count  = (32'(request.remove_count) > REMOVE_MAX)
                      ? RW'(REMOVE_MAX) : RW'(request.remove_count);
    assign take_count = (32'(cap_count) > 32'(fill_reg)) ? RW'(fill_reg) : cap_count;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [VALUE_BITS-1:0] left_value;
        logic                  left_gt;
        logic [VALUE_BITS-1:0] right_value;

        if (i == 0)
        begin : g_head
            assign left_value = ins_value;
            assign left_gt    = 1'b0;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
            assign left_gt    = cell_gt[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        sapq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (32'(fill_reg) > i),
            .ins_value   (ins_value),
            .left_value  (left_value),
            .left_gt     (left_gt),
            .right_value (right_value),
            .value       (cell_value[i]),
            .gt          (cell_gt[i])
        );
    end

    always_comb
    begin
        cmd       = '0;
        fill_next = fill_reg;
        rem_next  = rem_reg;
        done_next = 1'b0;
        res_next  = res_reg;

        if (rem_reg != '0)
        begin
            // draining the rest of a removal from the head
            cmd.shift = 1'b1;
            fill_next = fill_reg - 1'b1;
            rem_next  = rem_reg - 1'b1;
            done_next = 1'b1;
            res_next  = '{cell_value[0], 1'b1, (rem_reg == RW'(1)), 1'b0,
                          7'(fill_reg - 1'b1)};
        end
        else if (start)
        begin
            done_next = 1'b1;
            case (request.op)
                OP_INSERT:
                begin
                    if (32'(fill_reg) >= DEPTH)
                    begin
                        res_next = '{'0, 1'b0, 1'b1, 1'b1, 7'(fill_reg)};
                    end
                    else
                    begin
                        cmd.insert = 1'b1;
                        fill_next  = fill_reg + 1'b1;
                        res_next   = '{'0, 1'b0, 1'b1, 1'b0, 7'(fill_reg + 1'b1)};
                    end
                end
                OP_REMOVE:
                begin
                    if (take_count == '0)
                    begin
                        res_next = '{'0, 1'b0, 1'b1, 1'b0, 7'(fill_reg)};
                    end
                    else
                    begin
                        cmd.shift = 1'b1;
                        fill_next = fill_reg - 1'b1;
                        rem_next  = take_count - 1'b1;
                        res_next  = '{cell_value[0], 1'b1, (take_count == RW'(1)),
                                      1'b0, 7'(fill_reg - 1'b1)};
                    end
                end
                default:
                begin
                    res_next = '{'0, 1'b0, 1'b1, 1'b0, 7'(fill_reg)};
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            rem_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            rem_reg  <= rem_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// File: hdl/sapq_checker.sv
module sapq_checker
    import sapq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t request,
    input logic done,
    input res_t result
);

    // a drain cycle always yields a result in the next cycle
    a_busy_yields: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("busy cycle without a following result");

    // an insert transfer is answered by exactly one final result
    a_insert_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.op == OP_INSERT) |=> (done && result.last && !busy))
        else $error("insert not acknowledged in one cycle");

    // more results pending means the block holds off new transfers
    a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |-> busy)
        else $error("non-final result while not busy");

    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.has_value) |-> (result.last && result.removed_value == '0))
        else $error("empty result not final or not zero");

    a_drop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.dropped) |-> !result.has_value)
        else $error("dropped result carries a value");

endmodule

bind sorted_array_priority_queue_top sapq_checker u_sapq_checker (.*);
